// ===== rtl/core/rmsq_pkg.sv =====
// shared types, codes and scale helper functions for the random melody step quantizer
package rmsq_pkg;

   localparam int NOTES = 12;
   localparam int SEMI_STEPS = 64;
   localparam int OCT_STEPS = NOTES * SEMI_STEPS;
   localparam int WEIGHT_ONE = 4096;
   localparam int CHANCE_REGS = 7;

   localparam logic [2:0] ACT_JUMP  = 3'd0;
   localparam logic [2:0] ACT_SHIFT = 3'd1;
   localparam logic [2:0] ACT_UP2   = 3'd2;
   localparam logic [2:0] ACT_UP1   = 3'd3;
   localparam logic [2:0] ACT_DOWN1 = 3'd4;
   localparam logic [2:0] ACT_DOWN2 = 3'd5;
   localparam logic [2:0] ACT_STAY  = 3'd6;

   localparam logic [2:0] REG_JUMP   = 3'd0;
   localparam logic [2:0] REG_SHIFT  = 3'd1;
   localparam logic [2:0] REG_UP     = 3'd2;
   localparam logic [2:0] REG_DOWN   = 3'd3;
   localparam logic [2:0] REG_STAY   = 3'd4;
   localparam logic [2:0] REG_TWO    = 3'd5;
   localparam logic [2:0] REG_REPEAT = 3'd6;
   localparam logic [2:0] REG_MASK   = 3'd7;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_GUIDE = 1'b1;

   typedef logic signed [11:0] oct_type;
   typedef logic [9:0] frac_type;
   typedef logic [3:0] deg_type;
   typedef logic [12:0] weight_type;
   typedef logic [14:0] thr_type;
   typedef logic signed [11:0] bnd_type;

   typedef struct packed {
      oct_type o;
      frac_type f;
   } ptch_type;

   typedef struct packed {
      oct_type o;
      deg_type d;
   } pos_type;

   typedef struct {
      deg_type len;
      frac_type sp [NOTES];
      bnd_type bnd [NOTES + 1];
   } scale_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic thr;
      logic rq;
      logic chance;
      logic act;
      logic jq;
      logic minit;
      logic wrap;
      logic rev;
      logic commit;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic needs_rq;
      logic [2:0] action;
      logic wrap_done;
      logic move_bad;
      logic reversed;
      logic out_free;
   } sts_type;

   function automatic weight_type sat_weight(input weight_type v);
      weight_type r;
      r = (v > weight_type'(WEIGHT_ONE)) ? weight_type'(WEIGHT_ONE) : v;
      return r;
   endfunction

   function automatic logic p_gt(input oct_type o1, input frac_type f1,
                                 input oct_type o2, input frac_type f2);
      logic r;
      r = (o1 > o2) || ((o1 == o2) && (f1 > f2));
      return r;
   endfunction

   function automatic logic p_lt(input oct_type o1, input frac_type f1,
                                 input oct_type o2, input frac_type f2);
      logic r;
      r = (o1 < o2) || ((o1 == o2) && (f1 < f2));
      return r;
   endfunction

   function automatic scale_type build_scale(input logic [11:0] mask);
      scale_type s;
      logic [11:0] m;
      deg_type cnt;
      logic [11:0] sum;
      for (int i = 0; i < NOTES; i++) s.sp[i] = '0;
      for (int i = 0; i <= NOTES; i++) s.bnd[i] = '0;
      m = (mask == 12'd0) ? 12'd1 : mask;
      cnt = '0;
      for (int n = 0; n < NOTES; n++) begin
         if (m[n]) begin
            s.sp[cnt] = frac_type'(n * SEMI_STEPS);
            cnt = cnt + 4'd1;
         end
      end
      s.len = cnt;
      if (cnt == 4'd1) begin
         s.bnd[0] = bnd_type'($signed({2'b00, s.sp[0]}) - 12'sd384);
         s.bnd[1] = bnd_type'({1'b0, s.sp[0]});
      end else begin
         s.bnd[0] = bnd_type'(($signed({2'b00, s.sp[cnt - 4'd1]}) - 12'sd768) >>> 1);
         for (int i = 0; i < NOTES - 1; i++) begin
            if (i < int'(cnt) - 1) begin
               sum = {2'b00, s.sp[i]} + {2'b00, s.sp[i + 1]};
               s.bnd[i + 1] = bnd_type'({1'b0, sum[10:1]});
            end
         end
         sum = {2'b00, s.sp[0]} + 12'd768 + {2'b00, s.sp[cnt - 4'd1]};
         s.bnd[cnt] = bnd_type'({1'b0, sum[11:1]});
      end
      return s;
   endfunction

   // floor(p / 768) and the remainder, via floor(p / 256) and a reciprocal of three
   function automatic ptch_type fdiv768(input logic signed [14:0] p);
      ptch_type r;
      logic [7:0] x;
      logic [15:0] prod;
      logic signed [15:0] o16;
      logic signed [15:0] om;
      logic signed [15:0] fr;
      x = {p[14], p[14:8]} + 8'd66;
      prod = {8'b0, x} * 16'd171;
      r.o = oct_type'({5'b0, prod[15:9]}) - 12'sd22;
      o16 = {{4{r.o[11]}}, r.o};
      om = (o16 <<< 9) + (o16 <<< 8);
      fr = {p[14], p} - om;
      r.f = fr[9:0];
      return r;
   endfunction

   function automatic pos_type note_above(input ptch_type p, input scale_type s);
      pos_type r;
      logic found;
      r.o = p.o + 12'sd1;
      r.d = '0;
      found = 1'b0;
      for (int d = 0; d < NOTES; d++) begin
         if (!found && (d < int'(s.len)) && (s.sp[d] >= p.f)) begin
            r.o = p.o;
            r.d = deg_type'(d);
            found = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic pos_type note_below(input ptch_type p, input scale_type s);
      pos_type r;
      logic found;
      r.o = p.o - 12'sd1;
      r.d = s.len - 4'd1;
      found = 1'b0;
      for (int d = NOTES - 1; d >= 0; d--) begin
         if (!found && (d < int'(s.len)) && (s.sp[d] <= p.f)) begin
            r.o = p.o;
            r.d = deg_type'(d);
            found = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic pos_type quantize(input ptch_type v, input scale_type s,
                                        input ptch_type lo, input ptch_type hi);
      pos_type r;
      logic found;
      logic signed [11:0] fs;
      fs = $signed({2'b00, v.f});
      found = 1'b0;
      r.o = v.o;
      r.d = '0;
      if (fs < s.bnd[0]) begin
         r.o = v.o - 12'sd1;
         r.d = s.len - 4'd1;
      end else if (fs > s.bnd[s.len]) begin
         r.o = v.o + 12'sd1;
      end else begin
         for (int i = 0; i < NOTES; i++) begin
            if (!found && (i < int'(s.len)) && (fs <= s.bnd[i + 1])) begin
               r.d = deg_type'(i);
               found = 1'b1;
            end
         end
      end
      if (p_lt(r.o, s.sp[r.d], lo.o, lo.f)) r = note_above(lo, s);
      if (p_gt(r.o, s.sp[r.d], hi.o, hi.f)) r = note_below(hi, s);
      return r;
   endfunction

endpackage

// ===== rtl/core/random_melody_step_quantizer.sv =====
// random melody step quantizer top level
// a step word yields one result word after acceptance, with one more state on requantize;
// the degree wrap walk moves one scale length per cycle, before and after a reversal
// a guide word yields no result word
// one word in work; the next is accepted the cycle after a result word is loaded, and a result
// word still held at the output stalls the next step in its last state
// synchronous reset: settings cleared, scale mask root only, pitch state zero
module random_melody_step_quantizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // guide_pitch, force_jump, force_shift, force_stay, lower_limit, upper_limit,
   // jump_random, action_random
   input  logic [79:0]  req_tdata,
   // opcode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pitch
   output logic [15:0]  rsp_tdata,
   // action, limit_error
   output logic [3:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [12:0]  csr_wdata
);

   rmsq_pkg::cmd_type cmd;
   rmsq_pkg::sts_type sts;
   logic signed [13:0] pitch;
   logic [2:0] action;
   logic limit_error;

   rmsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser[0]),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   rmsq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_opcode        (req_tuser[0]),
      .req_guide_pitch   (req_tdata[13:0]),
      .req_force_jump    (req_tdata[14]),
      .req_force_shift   (req_tdata[15]),
      .req_force_stay    (req_tdata[16]),
      .req_lower_limit   (req_tdata[30:17]),
      .req_upper_limit   (req_tdata[44:31]),
      .req_jump_random   (req_tdata[60:45]),
      .req_action_random (req_tdata[76:61]),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_pitch         (pitch),
      .rsp_action        (action),
      .rsp_limit_error   (limit_error)
   );

   assign rsp_tdata = {2'b00, pitch};
   assign rsp_tuser = {limit_error, action};

endmodule

// ===== rtl/core/rmsq_ctrl.sv =====
// sequencing state machine for the random melody step quantizer
module rmsq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_opcode,
   input  rmsq_pkg::sts_type   sts,
   output logic                req_tready,
   output rmsq_pkg::cmd_type   cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PREP   = 4'd1;
   localparam logic [3:0] ST_THR    = 4'd2;
   localparam logic [3:0] ST_RQ     = 4'd3;
   localparam logic [3:0] ST_CHANCE = 4'd4;
   localparam logic [3:0] ST_ACT    = 4'd5;
   localparam logic [3:0] ST_JQ     = 4'd6;
   localparam logic [3:0] ST_MINIT  = 4'd7;
   localparam logic [3:0] ST_WRAP   = 4'd8;
   localparam logic [3:0] ST_CHK    = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_opcode == rmsq_pkg::OP_STEP) state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_THR;
         end
         ST_THR: begin
            cmd.thr = 1'b1;
            state_in = sts.needs_rq ? ST_RQ : ST_CHANCE;
         end
         ST_RQ: begin
            cmd.rq = 1'b1;
            state_in = ST_CHANCE;
         end
         ST_CHANCE: begin
            cmd.chance = 1'b1;
            state_in = ST_ACT;
         end
         ST_ACT: begin
            cmd.act = 1'b1;
            state_in = ST_MINIT;
         end
         ST_MINIT: begin
            priority if (sts.action == rmsq_pkg::ACT_JUMP ||
                         sts.action == rmsq_pkg::ACT_SHIFT) begin
               state_in = ST_JQ;
            end else if (sts.action == rmsq_pkg::ACT_STAY) begin
               state_in = ST_OUT;
            end else begin
               cmd.minit = 1'b1;
               state_in = ST_WRAP;
            end
         end
         ST_JQ: begin
            cmd.jq = 1'b1;
            state_in = ST_OUT;
         end
         ST_WRAP: begin
            if (sts.wrap_done) state_in = ST_CHK;
            else cmd.wrap = 1'b1;
         end
         ST_CHK: begin
            if (sts.move_bad && !sts.reversed) begin
               cmd.rev = 1'b1;
               state_in = ST_WRAP;
            end else begin
               cmd.commit = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   a_wrap_to_chk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRAP && sts.wrap_done) |=> (state_ff == ST_CHK))
      else $error("wrap walk did not hand over to the limit check");

endmodule

// ===== rtl/core/rmsq_dp.sv =====
// datapath of the random melody step quantizer: settings, pitch state and scale arithmetic
module rmsq_dp (
   input  logic                clock,
   input  logic                reset,
   input  rmsq_pkg::cmd_type   cmd,
   output rmsq_pkg::sts_type   sts,
   input  logic                csr_we,
   input  logic [2:0]          csr_addr,
   input  logic [12:0]         csr_wdata,
   input  logic                req_opcode,
   input  logic signed [13:0]  req_guide_pitch,
   input  logic                req_force_jump,
   input  logic                req_force_shift,
   input  logic                req_force_stay,
   input  logic signed [13:0]  req_lower_limit,
   input  logic signed [13:0]  req_upper_limit,
   input  logic [15:0]         req_jump_random,
   input  logic [15:0]         req_action_random,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output logic signed [13:0]  rsp_pitch,
   output logic [2:0]          rsp_action,
   output logic                rsp_limit_error
);

   localparam int NR = rmsq_pkg::CHANCE_REGS;

   rmsq_pkg::weight_type chance_reg_ff [NR];
   rmsq_pkg::weight_type chance_reg_in [NR];
   logic [11:0] mask_ff, mask_in;
   rmsq_pkg::scale_type scale_ff;
   logic needs_rq_ff, needs_rq_in;
   logic last_stay_ff, last_stay_in;
   rmsq_pkg::ptch_type lp_ff, lp_in;
   rmsq_pkg::pos_type cur_ff, cur_in;
   logic fj_ff, fj_in, fs_ff, fs_in, fst_ff, fst_in;
   logic signed [13:0] lo_raw_ff, lo_raw_in, hi_raw_ff, hi_raw_in;
   logic [15:0] jr_ff, jr_in, ar_ff, ar_in;
   rmsq_pkg::ptch_type lo_ff, lo_in, hi_ff, hi_in, tgt_ff, tgt_in;
   logic signed [31:0] prod_j_ff, prod_j_in;
   logic [25:0] prod_uf_ff, prod_uf_in, prod_df_ff, prod_df_in, prod_st_ff, prod_st_in;
   rmsq_pkg::thr_type thr_ff [NR];
   rmsq_pkg::thr_type thr_in [NR];
   rmsq_pkg::thr_type top_ff, top_in, chance_ff, chance_in;
   logic err_ff, err_in;
   logic [2:0] action_ff, action_in;
   rmsq_pkg::ptch_type res_ff, res_in;
   logic signed [4:0] idx_ff, idx_in;
   rmsq_pkg::oct_type wr_ff, wr_in;
   logic rev_ff, rev_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [13:0] rsp_pitch_ff, rsp_pitch_in;
   logic [2:0] rsp_action_ff, rsp_action_in;
   logic rsp_err_ff, rsp_err_in;

   rmsq_pkg::weight_type wj, ws, wu, wd, wst, wf, wrep;
   rmsq_pkg::pos_type q_pos, ea;
   rmsq_pkg::ptch_type q_in;
   rmsq_pkg::oct_type cand_o;
   rmsq_pkg::frac_type cand_f;
   logic signed [4:0] len5, mval;
   logic move_up, wrap_done, move_bad;
   logic signed [14:0] span;
   logic signed [15:0] tsum;
   logic [30:0] prod_c;
   logic signed [21:0] o22, pfull;
   logic found;

   assign wj = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_JUMP]);
   assign ws = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_SHIFT]);
   assign wu = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_UP]);
   assign wd = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_DOWN]);
   assign wst = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_STAY]);
   assign wf = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_TWO]);
   assign wrep = rmsq_pkg::sat_weight(chance_reg_ff[rmsq_pkg::REG_REPEAT]);

   assign q_in = cmd.rq ? lp_ff : tgt_ff;
   assign q_pos = rmsq_pkg::quantize(q_in, scale_ff, lo_ff, hi_ff);
   assign ea = rmsq_pkg::note_above(lo_ff, scale_ff);

   assign len5 = $signed({1'b0, scale_ff.len});
   assign wrap_done = !idx_ff[4] && (idx_ff < len5);
   assign cand_o = cur_ff.o + wr_ff;
   assign cand_f = scale_ff.sp[idx_ff[3:0]];
   assign move_up = (action_ff == rmsq_pkg::ACT_UP2) || (action_ff == rmsq_pkg::ACT_UP1);
   assign move_bad = move_up ? rmsq_pkg::p_gt(cand_o, cand_f, hi_ff.o, hi_ff.f)
                             : rmsq_pkg::p_lt(cand_o, cand_f, lo_ff.o, lo_ff.f);

   always_comb begin
      unique case (action_ff)
         rmsq_pkg::ACT_UP2:   mval = 5'sd2;
         rmsq_pkg::ACT_UP1:   mval = 5'sd1;
         rmsq_pkg::ACT_DOWN1: mval = -5'sd1;
         rmsq_pkg::ACT_DOWN2: mval = -5'sd2;
         default:             mval = 5'sd0;
      endcase
   end

   assign span = {hi_raw_ff[13], hi_raw_ff} - {lo_raw_ff[13], lo_raw_ff};
   assign tsum = {{2{lo_raw_ff[13]}}, lo_raw_ff} + prod_j_ff[31:16];
   assign prod_c = {15'b0, ar_ff} * {16'b0, top_ff};
   assign o22 = {{10{res_ff.o[11]}}, res_ff.o};
   assign pfull = (o22 <<< 9) + (o22 <<< 8) + $signed({12'b0, res_ff.f});

   assign sts.needs_rq = needs_rq_ff;
   assign sts.action = action_ff;
   assign sts.wrap_done = wrap_done;
   assign sts.move_bad = move_bad;
   assign sts.reversed = rev_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      chance_reg_in = chance_reg_ff;
      mask_in = mask_ff;
      needs_rq_in = needs_rq_ff;
      last_stay_in = last_stay_ff;
      lp_in = lp_ff;
      cur_in = cur_ff;
      fj_in = fj_ff;
      fs_in = fs_ff;
      fst_in = fst_ff;
      lo_raw_in = lo_raw_ff;
      hi_raw_in = hi_raw_ff;
      jr_in = jr_ff;
      ar_in = ar_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      tgt_in = tgt_ff;
      prod_j_in = prod_j_ff;
      prod_uf_in = prod_uf_ff;
      prod_df_in = prod_df_ff;
      prod_st_in = prod_st_ff;
      thr_in = thr_ff;
      top_in = top_ff;
      chance_in = chance_ff;
      err_in = err_ff;
      action_in = action_ff;
      res_in = res_ff;
      idx_in = idx_ff;
      wr_in = wr_ff;
      rev_in = rev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_action_in = rsp_action_ff;
      rsp_err_in = rsp_err_ff;
      found = 1'b0;

      if (csr_we) begin
         if (csr_addr == rmsq_pkg::REG_MASK) begin
            mask_in = csr_wdata[11:0];
         end else if (chance_reg_ff[csr_addr] != csr_wdata) begin
            chance_reg_in[csr_addr] = csr_wdata;
            needs_rq_in = 1'b1;
         end
      end

      if (cmd.load) begin
         if (req_opcode == rmsq_pkg::OP_GUIDE) begin
            lp_in = rmsq_pkg::fdiv768({req_guide_pitch[13], req_guide_pitch});
            needs_rq_in = 1'b1;
         end
         fj_in = req_force_jump;
         fs_in = req_force_shift;
         fst_in = req_force_stay;
         lo_raw_in = req_lower_limit;
         hi_raw_in = req_upper_limit;
         jr_in = req_jump_random;
         ar_in = req_action_random;
      end

      if (cmd.prep) begin
         lo_in = rmsq_pkg::fdiv768({lo_raw_ff[13], lo_raw_ff});
         hi_in = rmsq_pkg::fdiv768({hi_raw_ff[13], hi_raw_ff});
         prod_j_in = $signed({1'b0, jr_ff}) * span;
         prod_uf_in = wu * wf;
         prod_df_in = wd * (13'd4096 - wf);
         prod_st_in = wst * (13'd4096 - wrep);
      end

      if (cmd.thr) begin
         thr_in[0] = {2'b0, wj};
         thr_in[1] = {2'b0, wj} + {2'b0, ws};
         thr_in[2] = thr_in[1] + {2'b0, prod_uf_ff[24:12]};
         thr_in[3] = thr_in[1] + {2'b0, wu};
         thr_in[4] = thr_in[3] + {2'b0, prod_df_ff[24:12]};
         thr_in[5] = thr_in[3] + {2'b0, wd};
         thr_in[6] = thr_in[5] + {2'b0, wst};
         top_in = thr_in[6] - (last_stay_ff ? {2'b0, prod_st_ff[24:12]} : 15'd0);
         tgt_in = rmsq_pkg::fdiv768(tsum[14:0]);
         err_in = rmsq_pkg::p_gt(ea.o, scale_ff.sp[ea.d], hi_ff.o, hi_ff.f);
      end

      if (cmd.rq) begin
         cur_in = q_pos;
         lp_in.o = q_pos.o;
         lp_in.f = scale_ff.sp[q_pos.d];
      end

      if (cmd.chance) chance_in = prod_c[30:16];

      if (cmd.act) begin
         res_in = lp_ff;
         priority if (fj_ff) begin
            action_in = rmsq_pkg::ACT_JUMP;
         end else if (fs_ff) begin
            action_in = rmsq_pkg::ACT_SHIFT;
         end else if (fst_ff) begin
            action_in = rmsq_pkg::ACT_STAY;
         end else begin
            action_in = rmsq_pkg::ACT_JUMP;
            for (int i = 0; i < NR; i++) begin
               if (!found && (thr_ff[i] >= chance_ff)) begin
                  action_in = 3'(i);
                  found = 1'b1;
               end
            end
         end
      end

      if (cmd.jq) begin
         res_in.o = q_pos.o;
         res_in.f = scale_ff.sp[q_pos.d];
         if (action_ff == rmsq_pkg::ACT_SHIFT) begin
            cur_in = q_pos;
            lp_in = res_in;
         end
      end

      if (cmd.minit) begin
         idx_in = $signed({1'b0, cur_ff.d}) + mval;
         wr_in = '0;
         rev_in = 1'b0;
      end

      if (cmd.rev) begin
         idx_in = $signed({1'b0, cur_ff.d}) - mval;
         wr_in = '0;
         rev_in = 1'b1;
      end

      if (cmd.wrap) begin
         if (idx_ff[4]) begin
            idx_in = idx_ff + len5;
            wr_in = wr_ff - 12'sd1;
         end else begin
            idx_in = idx_ff - len5;
            wr_in = wr_ff + 12'sd1;
         end
      end

      if (cmd.commit) begin
         cur_in.o = cand_o;
         cur_in.d = idx_ff[3:0];
         res_in.o = cand_o;
         res_in.f = cand_f;
         lp_in = res_in;
      end

      if (cmd.out) begin
         rsp_valid_in = 1'b1;
         if (pfull > 22'sd8191) rsp_pitch_in = 14'sd8191;
         else if (pfull < -22'sd8192) rsp_pitch_in = -14'sd8192;
         else rsp_pitch_in = pfull[13:0];
         rsp_action_in = action_ff;
         rsp_err_in = err_ff;
         last_stay_in = (action_ff == rmsq_pkg::ACT_STAY);
         needs_rq_in = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NR; i++) chance_reg_ff[i] <= '0;
         mask_ff <= 12'd1;
         needs_rq_ff <= 1'b0;
         last_stay_ff <= 1'b0;
         lp_ff <= '0;
         cur_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chance_reg_ff <= chance_reg_in;
         mask_ff <= mask_in;
         needs_rq_ff <= needs_rq_in;
         last_stay_ff <= last_stay_in;
         lp_ff <= lp_in;
         cur_ff <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_ff <= rmsq_pkg::build_scale(mask_ff);
      fj_ff <= fj_in;
      fs_ff <= fs_in;
      fst_ff <= fst_in;
      lo_raw_ff <= lo_raw_in;
      hi_raw_ff <= hi_raw_in;
      jr_ff <= jr_in;
      ar_ff <= ar_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      tgt_ff <= tgt_in;
      prod_j_ff <= prod_j_in;
      prod_uf_ff <= prod_uf_in;
      prod_df_ff <= prod_df_in;
      prod_st_ff <= prod_st_in;
      thr_ff <= thr_in;
      top_ff <= top_in;
      chance_ff <= chance_in;
      err_ff <= err_in;
      action_ff <= action_in;
      res_ff <= res_in;
      idx_ff <= idx_in;
      wr_ff <= wr_in;
      rev_ff <= rev_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_action_ff <= rsp_action_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pitch = rsp_pitch_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_limit_error = rsp_err_ff;

   a_out_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.out |=> rsp_valid_ff)
      else $error("result word not presented after output command");

   a_commit_in_scale: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!idx_ff[4] && idx_ff < len5))
      else $error("committed degree outside the scale");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      cmd.out |-> (action_ff != 3'd7))
      else $error("undefined action code reaches the output");

endmodule
